// ===== src/scfc_pkg.sv =====
// ----------------------------------------------------------------------------
// scfc_pkg
// types, register indexes and the crc-32 byte step shared by the frame checker
// ----------------------------------------------------------------------------
package scfc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_BYTES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECEIVER_CAPACITY = 3'd4;

    localparam logic [15:0] SYNC_RESET     = 16'hA53C;
    localparam logic [7:0]  LIMIT_RESET    = 8'd255;
    localparam logic [7:0]  PREAMBLE_RESET = 8'd64;
    localparam logic [5:0]  HEADER_RESET   = 6'd8;
    localparam logic [7:0]  CAPACITY_RESET = 8'd255;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [2:0]  CRC_BYTES = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_word;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       frame_good;
        logic [7:0] payload_count;
    } t_out_word;

    typedef struct packed {
        logic [15:0] sync_pattern;
        logic [7:0]  payload_limit;
        logic [7:0]  preamble_bytes;
        logic [5:0]  header_bytes;
        logic [7:0]  receiver_capacity;
    } t_cfg;

    // results produced by one accepted word, slot 0 first
    typedef struct packed {
        logic [1:0] count;
        t_out_word  slot0;
        t_out_word  slot1;
    } t_emit;

    // reflected crc-32, one byte per call
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== src/scfc_frame.sv =====
// ----------------------------------------------------------------------------
// scfc_frame
// frame phase tracking, sync compare, length check and crc-32 per word
// ----------------------------------------------------------------------------
module scfc_frame
    import scfc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_word i_in,
    input  t_cfg     i_cfg,
    output t_emit    o_emit
);

    localparam logic [2:0] PH_PRE   = 3'd0;
    localparam logic [2:0] PH_SYNC0 = 3'd1;
    localparam logic [2:0] PH_SYNC1 = 3'd2;
    localparam logic [2:0] PH_HDR   = 3'd3;
    localparam logic [2:0] PH_PAY   = 3'd4;
    localparam logic [2:0] PH_CRC   = 3'd5;
    localparam logic [2:0] PH_TAIL  = 3'd6;

    localparam t_out_word BAD_VERDICT = '{out_kind: KIND_VERDICT, out_byte: 8'd0,
                                          frame_good: 1'b0, payload_count: 8'd0};

    logic [2:0]  r_phase,   n_phase;
    logic [7:0]  r_pos,     n_pos;
    logic [7:0]  r_sync0,   n_sync0;
    logic [7:0]  r_length,  n_length;
    logic [31:0] r_crc,     n_crc;
    logic [31:0] r_rx_crc,  n_rx_crc;
    logic        r_verdict, n_verdict;

    logic [5:0]  hlen;
    logic [2:0]  ph;
    logic [7:0]  pos;
    logic [7:0]  pos_inc;
    logic [31:0] crc_step;
    logic        hit;
    t_out_word   res;
    logic        good;

    assign hlen     = (i_cfg.header_bytes == 6'd0) ? 6'd1 : i_cfg.header_bytes;
    assign crc_step = crc_byte(r_crc, i_in.rx_byte);

    always_comb begin
        ph        = r_phase;
        pos       = r_pos;
        n_phase   = r_phase;
        n_sync0   = r_sync0;
        n_length  = r_length;
        n_crc     = r_crc;
        n_rx_crc  = r_rx_crc;
        n_verdict = r_verdict;
        hit       = 1'b0;
        res       = BAD_VERDICT;
        good      = 1'b0;

        // preamble done: this word is the first sync byte
        if (r_phase == PH_PRE && r_pos >= i_cfg.preamble_bytes) begin
            ph  = PH_SYNC0;
            pos = 8'd0;
        end
        pos_inc = pos + 8'd1;
        n_pos   = pos;
        n_phase = ph;

        case (ph)
            PH_PRE: begin
                n_pos = pos_inc;
            end
            PH_SYNC0: begin
                n_sync0 = i_in.rx_byte;
                n_phase = PH_SYNC1;
            end
            PH_SYNC1: begin
                if ({r_sync0, i_in.rx_byte} != i_cfg.sync_pattern) begin
                    hit       = 1'b1;
                    n_verdict = 1'b1;
                    n_phase   = PH_TAIL;
                end else begin
                    n_phase = PH_HDR;
                    n_pos   = 8'd0;
                end
            end
            PH_HDR: begin
                n_crc = crc_step;
                if (pos == 8'd0) begin
                    n_length = i_in.rx_byte;
                end
                if (pos == 8'd0 && (i_in.rx_byte > i_cfg.payload_limit ||
                                    i_in.rx_byte > i_cfg.receiver_capacity)) begin
                    hit       = 1'b1;
                    n_verdict = 1'b1;
                    n_phase   = PH_TAIL;
                end else if (pos_inc >= {2'd0, hlen}) begin
                    n_pos   = 8'd0;
                    n_phase = (n_length == 8'd0) ? PH_CRC : PH_PAY;
                end else begin
                    n_pos = pos_inc;
                end
            end
            PH_PAY: begin
                n_crc = crc_step;
                hit   = 1'b1;
                res   = '{out_kind: KIND_PAYLOAD, out_byte: i_in.rx_byte,
                          frame_good: 1'b0, payload_count: 8'd0};
                if (pos_inc >= r_length) begin
                    n_pos   = 8'd0;
                    n_phase = PH_CRC;
                end else begin
                    n_pos = pos_inc;
                end
            end
            PH_CRC: begin
                n_rx_crc = {r_rx_crc[23:0], i_in.rx_byte};
                n_pos    = pos_inc;
                if (pos_inc >= {5'd0, CRC_BYTES}) begin
                    good      = ((r_crc ^ CRC_INIT) == n_rx_crc);
                    hit       = 1'b1;
                    res       = '{out_kind: KIND_VERDICT, out_byte: 8'd0,
                                  frame_good: good,
                                  payload_count: good ? r_length : 8'd0};
                    n_verdict = 1'b1;
                    n_phase   = PH_TAIL;
                end
            end
            default: begin
            end
        endcase

        // results: stage result first, then a truncation verdict if needed
        o_emit.slot0 = hit ? res : BAD_VERDICT;
        o_emit.slot1 = BAD_VERDICT;
        if (i_in.frame_end && !n_verdict) begin
            o_emit.count = hit ? 2'd2 : 2'd1;
        end else begin
            o_emit.count = hit ? 2'd1 : 2'd0;
        end

        if (i_in.frame_end) begin
            n_phase   = PH_PRE;
            n_pos     = 8'd0;
            n_sync0   = 8'd0;
            n_length  = 8'd0;
            n_crc     = CRC_INIT;
            n_rx_crc  = 32'd0;
            n_verdict = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_PRE;
            r_pos     <= 8'd0;
            r_sync0   <= 8'd0;
            r_length  <= 8'd0;
            r_crc     <= CRC_INIT;
            r_rx_crc  <= 32'd0;
            r_verdict <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_sync0   <= n_sync0;
            r_length  <= n_length;
            r_crc     <= n_crc;
            r_rx_crc  <= n_rx_crc;
            r_verdict <= n_verdict;
        end
    end

    // two results only when the frame ends early
    a_two_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_emit.count == 2'd2) |-> i_in.frame_end)
        else $error("two results without frame end");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_in.frame_end) |=> (r_phase == PH_PRE && r_crc == CRC_INIT
                                          && !r_verdict))
        else $error("frame state not cleared at frame end");

    a_tail_has_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TAIL) |-> r_verdict)
        else $error("tail phase without verdict");

endmodule

// ===== src/scfc_out_queue.sv =====
// ----------------------------------------------------------------------------
// scfc_out_queue
// small result queue, takes up to two words per cycle, gives one per ready cycle
// ----------------------------------------------------------------------------
module scfc_out_queue
    import scfc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_emit     i_emit,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    t_out_word     r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] wr_next;
    logic [1:0]    push_n;
    logic          pop;

    assign o_room  = (r_count <= ROOM_MAX);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign push_n  = i_push ? i_emit.count : 2'd0;
    assign wr_next = wrap_inc(r_wr);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = pop ? wrap_inc(r_rd) : r_rd;
        n_count = r_count + CW'(push_n) - CW'(pop);
        case (push_n)
            2'd1:    n_wr = wr_next;
            2'd2:    n_wr = wrap_inc(wr_next);
            default: n_wr = r_wr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr] <= i_emit.slot0;
        end
        if (push_n == 2'd2) begin
            r_mem[wr_next] <= i_emit.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_only_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n != 2'd0) |-> o_room)
        else $error("push into full result queue");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push && !pop) |=> $stable(r_count))
        else $error("queue count moved while idle");

endmodule

// ===== src/sync_crc_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// sync_crc_frame_checker_core
// sync word, length and crc-32 frame checker for a received byte stream
// ----------------------------------------------------------------------------
// one received byte is taken per clock; each byte is handled in the cycle it is
// accepted (phase logic and a bytewise crc-32 step) and its results go into a
// small result queue. a byte gives at most two results, the second only when a
// frame ends early, so the sustained rate is one byte per cycle as long as the
// consumer takes one word per cycle; input ready drops only when the result
// queue has fewer than two free entries. the user must write registers through
// the plain write port only while the block is idle; no logic enforces it.
module sync_crc_frame_checker_core
    import scfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data
);

    t_cfg  r_cfg;
    t_emit emit;
    logic  accept;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_pattern      <= SYNC_RESET;
            r_cfg.payload_limit     <= LIMIT_RESET;
            r_cfg.preamble_bytes    <= PREAMBLE_RESET;
            r_cfg.header_bytes      <= HEADER_RESET;
            r_cfg.receiver_capacity <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SYNC_PATTERN:      r_cfg.sync_pattern      <= i_cfg_data;
                REG_PAYLOAD_LIMIT:     r_cfg.payload_limit     <= i_cfg_data[7:0];
                REG_PREAMBLE_BYTES:    r_cfg.preamble_bytes    <= i_cfg_data[7:0];
                REG_HEADER_BYTES:      r_cfg.header_bytes      <= i_cfg_data[5:0];
                REG_RECEIVER_CAPACITY: r_cfg.receiver_capacity <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    scfc_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in_data),
        .i_cfg    (r_cfg),
        .o_emit   (emit)
    );

    scfc_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_emit  (emit),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
